// File: rtl/clc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_pkg: shared types, constants and keystream function
// Holds the generator state type, the queue head type, the configuration
// register codes and the eight-step keystream function.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Field and register widths
    localparam int DATA_W        = 8;
    localparam int GEN12_W       = 12;
    localparam int GEN19_W       = 19;
    localparam int GEN17_W       = 17;
    localparam int GEN8_W        = 8;
    localparam int CFG_DATA_W    = 19;
    localparam int CFG_INDEX_W   = 2;

    // Default depth of the front-to-back queue (at least 2)
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEED_TWELVE    = 2'd0,
        CFG_SEED_NINETEEN  = 2'd1,
        CFG_SEED_SEVENTEEN = 2'd2,
        CFG_SEED_EIGHT     = 2'd3
    } cfg_index_t;

    // All four generator registers
    typedef struct packed {
        logic [GEN12_W-1:0] twelve;
        logic [GEN19_W-1:0] nineteen;
        logic [GEN17_W-1:0] seventeen;
        logic [GEN8_W-1:0]  eight;
    } gen_state_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              last;
    } queue_head_t;

    // One keystream byte and the generator state after it
    typedef struct packed {
        gen_state_t        gens;
        logic [DATA_W-1:0] key;
    } keystream_t;

    // Eight unrolled steps of all four generators, first key bit in bit 0
    function automatic keystream_t next_keystream(input gen_state_t s);
        gen_state_t        g;
        logic [DATA_W-1:0] key;
        logic              fb12;
        logic              fb19;
        logic              fb17;
        logic              fb8;
        keystream_t        res;
        g   = s;
        key = '0;
        for (int k = 0; k < DATA_W; k++)
        begin
            // taps 11,10,9,3,0
            fb12 = g.twelve[11] ^ g.twelve[10] ^ g.twelve[9] ^ g.twelve[3] ^ g.twelve[0];
            // taps 18,17,16,13,0
            fb19 = g.nineteen[18] ^ g.nineteen[17] ^ g.nineteen[16] ^ g.nineteen[13]
                 ^ g.nineteen[0];
            // taps 16,13,0
            fb17 = g.seventeen[16] ^ g.seventeen[13] ^ g.seventeen[0];
            // taps 7,5,4,0
            fb8  = g.eight[7] ^ g.eight[5] ^ g.eight[4] ^ g.eight[0];
            g.twelve    = {fb12, g.twelve[GEN12_W-1:1]};
            g.nineteen  = {fb19, g.nineteen[GEN19_W-1:1]};
            g.seventeen = {fb17, g.seventeen[GEN17_W-1:1]};
            g.eight     = {fb8, g.eight[GEN8_W-1:1]};
            key[k] = g.twelve[0] ^ g.nineteen[0] ^ g.seventeen[0] ^ g.eight[0] ^ 1'b1;
        end
        res.gens = g;
        res.key  = key;
        return res;
    endfunction

endpackage

// File: rtl/clc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_if: valid/ready stream interfaces
// Input word carries a data byte and the message end flag; output word
// carries the combined byte and the keystream byte.
// ----------------------------------------------------------------------------
interface clc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       last_byte;

    modport source (output valid, output data_in, output last_byte, input ready);
    modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

interface clc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [7:0] key_out;

    modport source (output valid, output data_out, output key_out, input ready);
    modport sink   (input valid, input data_out, input key_out, output ready);
endinterface

// File: rtl/clc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_front: input side and word queue
// Accepts input words whenever the queue has room and presents the oldest
// queued word, with its message end flag, to the back end.
// ----------------------------------------------------------------------------
module clc_front #(
    parameter int QUEUE_DEPTH = clc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    clc_in_if.sink              in_word,
    output clc_pkg::queue_head_t head,
    input  logic                pop
);
    import clc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] data_reg [QUEUE_DEPTH];
    logic              last_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;

    // room in the queue
    assign in_word.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push          = in_word.valid && in_word.ready;

    // oldest word to the back end
    assign head.valid = (count_reg != '0);
    assign head.data  = data_reg[rd_ptr_reg];
    assign head.last  = last_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_word.data_in;
            last_reg[wr_ptr_reg] <= in_word.last_byte;
        end
    end

endmodule

// File: rtl/clc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_back: keystream generators and output register
// Holds seeds and four generators; takes one queued word per cycle unless the
// output is stalled, makes its keystream byte, reloads seeds at message end.
// ----------------------------------------------------------------------------
module clc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  clc_pkg::queue_head_t               head,
    output logic                               pop,
    input  logic                               cfg_we,
    input  logic [clc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]     cfg_data,
    clc_out_if.source                          out_word
);
    import clc_pkg::*;

    gen_state_t        seed_reg;
    gen_state_t        seed_next;
    gen_state_t        gen_reg;
    gen_state_t        gen_next;
    keystream_t        ks;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] data_out_reg;
    logic [DATA_W-1:0] key_out_reg;

    // take a word when the output register is free or draining
    assign pop = head.valid && (!out_valid_reg || out_word.ready);
    assign ks  = next_keystream(gen_reg);

    assign out_word.valid    = out_valid_reg;
    assign out_word.data_out = data_out_reg;
    assign out_word.key_out  = key_out_reg;

    // seed and generator update
    always_comb
    begin
        seed_next = seed_reg;
        gen_next  = gen_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SEED_TWELVE:
                begin
                    seed_next.twelve = cfg_data[GEN12_W-1:0];
                    gen_next.twelve  = cfg_data[GEN12_W-1:0];
                end
                CFG_SEED_NINETEEN:
                begin
                    seed_next.nineteen = cfg_data[GEN19_W-1:0];
                    gen_next.nineteen  = cfg_data[GEN19_W-1:0];
                end
                CFG_SEED_SEVENTEEN:
                begin
                    seed_next.seventeen = cfg_data[GEN17_W-1:0];
                    gen_next.seventeen  = cfg_data[GEN17_W-1:0];
                end
                CFG_SEED_EIGHT:
                begin
                    seed_next.eight = cfg_data[GEN8_W-1:0];
                    gen_next.eight  = cfg_data[GEN8_W-1:0];
                end
                default:
                begin
                    seed_next = seed_reg;
                end
            endcase
        end
        else if (pop)
        begin
            // message end reloads every generator from its seed
            gen_next = head.last ? seed_reg : ks.gens;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_word.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg.twelve    <= GEN12_W'(1);
            seed_reg.nineteen  <= GEN19_W'(1);
            seed_reg.seventeen <= GEN17_W'(1);
            seed_reg.eight     <= GEN8_W'(1);
            gen_reg.twelve     <= GEN12_W'(1);
            gen_reg.nineteen   <= GEN19_W'(1);
            gen_reg.seventeen  <= GEN17_W'(1);
            gen_reg.eight      <= GEN8_W'(1);
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_out_reg <= head.data ^ ks.key;
            key_out_reg  <= ks.key;
        end
    end

endmodule

// File: rtl/combined_lfsr_stream_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lfsr_stream_cipher_top: four-LFSR stream cipher, one byte a word
// Path: an accepted word passes the queue, then the output register.
// Throughput: one word per cycle while the output is not stalled; eight
// generator steps are unrolled in the back end's single keystream stage.
// Reset: seeds and generators load 1, queue empty, output register empty.
// ----------------------------------------------------------------------------
module combined_lfsr_stream_cipher_top #(
    parameter int QUEUE_DEPTH = clc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    clc_in_if.sink                          in_word,
    clc_out_if.source                       out_word,
    input  logic                            cfg_we,
    input  logic [clc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clc_pkg::*;

    queue_head_t head;
    logic        pop;

    // input side and queue
    clc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word),
        .head    (head),
        .pop     (pop)
    );

    // keystream and output
    clc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word)
    );

    // back end only takes a word that is queued
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");

    // an accepted word is queued in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_word.valid && in_word.ready) |=> head.valid)
        else $error("accepted word lost from queue");

    // a taken word shows at the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_word.valid)
        else $error("taken word missing at output");

endmodule
